@@ sv/scs1_pkg.sv @@
package scs1_pkg;

   localparam int LAYOUTS_DEFAULT        = 3;
   localparam int KEYMAP_ENTRIES_DEFAULT = 128;

   // scan codes carry a 7 bit key number, so the key bitmap is fixed
   localparam int KEY_COUNT   = 128;
   localparam int MAX_CHARS   = 4;
   localparam int CSR_DATA_W  = 2;

   typedef logic [7:0] char_type;
   typedef logic [6:0] key_type;
   typedef logic [8:0] entry_type;

   typedef enum logic {
      KIND_SCAN      = 1'b0,
      KIND_MAP_WRITE = 1'b1
   } item_kind_type;

   typedef enum logic {
      CSR_REPEAT_ENABLE = 1'b0,
      CSR_LAYOUT_SELECT = 1'b1
   } csr_index_type;

   // prefix bytes
   localparam char_type SC_PREFIX_EXT   = 8'hE0;
   localparam char_type SC_PREFIX_PAUSE = 8'hE1;

   // key numbers
   localparam key_type KEY_BACKSPACE = 7'h0E;
   localparam key_type KEY_ENTER     = 7'h1C;
   localparam key_type KEY_CTRL      = 7'h1D;
   localparam key_type KEY_LSHIFT    = 7'h2A;
   localparam key_type KEY_RSHIFT    = 7'h36;
   localparam key_type KEY_ALT       = 7'h38;
   localparam key_type KEY_CAPS      = 7'h3A;
   localparam key_type KEY_NUM       = 7'h45;
   localparam key_type KEY_SCROLL    = 7'h46;
   localparam key_type KEY_HOME      = 7'h47;
   localparam key_type KEY_UP        = 7'h48;
   localparam key_type KEY_LEFT      = 7'h4B;
   localparam key_type KEY_RIGHT     = 7'h4D;
   localparam key_type KEY_END       = 7'h4F;
   localparam key_type KEY_DOWN      = 7'h50;
   localparam key_type KEY_DELETE    = 7'h53;

   // characters
   localparam char_type CH_BACKSPACE = 8'h08;
   localparam char_type CH_NEWLINE   = 8'h0A;
   localparam char_type CH_ESC       = 8'h1B;
   localparam char_type CH_BRACKET   = 8'h5B;
   localparam char_type CH_THREE     = 8'h33;
   localparam char_type CH_TILDE     = 8'h7E;
   localparam char_type CH_AT        = 8'h40;
   localparam char_type CH_UNDERSCORE = 8'h5F;
   localparam char_type CH_LOWER_A   = 8'h61;
   localparam char_type CH_LOWER_Z   = 8'h7A;
   localparam char_type CH_CASE_BIT  = 8'h20;
   localparam char_type CH_FIN_UP    = 8'h41;
   localparam char_type CH_FIN_DOWN  = 8'h42;
   localparam char_type CH_FIN_RIGHT = 8'h43;
   localparam char_type CH_FIN_LEFT  = 8'h44;
   localparam char_type CH_FIN_END   = 8'h46;
   localparam char_type CH_FIN_HOME  = 8'h48;

   // modifier bit positions
   localparam int MOD_SHIFT_L = 0;
   localparam int MOD_SHIFT_R = 1;
   localparam int MOD_CTRL_L  = 2;
   localparam int MOD_CTRL_R  = 3;
   localparam int MOD_ALT_L   = 4;
   localparam int MOD_ALT_R   = 5;

   // lock bit positions
   localparam int LOCK_CAPS   = 0;
   localparam int LOCK_NUM    = 1;
   localparam int LOCK_SCROLL = 2;

   typedef struct packed {
      char_type [MAX_CHARS-1:0] chars;
      logic [2:0]               count;
      logic                     reboot;
      logic [2:0]               locks;
   } bundle_type;

endpackage

@@ sv/scs1_if.sv @@
interface scs1_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] code;
   logic [1:0] map_layout;
   logic       map_upper;
   logic [8:0] map_entry;

   modport source (output valid, kind, code, map_layout, map_upper, map_entry,
                   input ready);
   modport sink   (input valid, kind, code, map_layout, map_upper, map_entry,
                   output ready);
endinterface

interface scs1_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_char;
   logic [7:0] out_char;
   logic       last;
   logic       reboot_request;
   logic       caps_on;
   logic       num_on;
   logic       scroll_on;

   modport source (output valid, has_char, out_char, last, reboot_request, caps_on,
                   num_on, scroll_on, input ready);
   modport sink   (input valid, has_char, out_char, last, reboot_request, caps_on,
                   num_on, scroll_on, output ready);
endinterface

@@ sv/scs1_keymap_ram.sv @@
module scs1_keymap_ram #(
   parameter int LAYOUTS        = scs1_pkg::LAYOUTS_DEFAULT,
   parameter int KEYMAP_ENTRIES = scs1_pkg::KEYMAP_ENTRIES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      wr_enable,
   input  logic [1:0]                wr_layout,
   input  logic                      wr_upper,
   input  scs1_pkg::key_type         wr_index,
   input  scs1_pkg::entry_type       wr_data,
   input  logic                      rd_enable,
   input  logic [1:0]                rd_layout,
   input  scs1_pkg::key_type         rd_index,
   output scs1_pkg::entry_type [1:0] rd_data
);
   import scs1_pkg::*;

   localparam int DEPTH = LAYOUTS * KEYMAP_ENTRIES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // each word holds the unshifted and shifted entry of one key
   entry_type         mem [DEPTH][2];
   entry_type [1:0]   rd_data_ff;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;

   assign wr_addr = AW'(int'(wr_layout) * KEYMAP_ENTRIES + int'(wr_index));
   assign rd_addr = AW'(int'(rd_layout) * KEYMAP_ENTRIES + int'(rd_index));

   always_ff @(posedge clock) begin
      if (wr_enable) begin
         mem[wr_addr][wr_upper] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_enable) begin
         rd_data_ff[0] <= mem[rd_addr][0];
         rd_data_ff[1] <= mem[rd_addr][1];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/scs1_keydown_ram.sv @@
module scs1_keydown_ram (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_enable,
   input  scs1_pkg::key_type wr_index,
   input  logic              wr_data,
   input  logic              rd_enable,
   input  scs1_pkg::key_type rd_index,
   output logic              rd_data
);
   import scs1_pkg::*;

   logic                 mem [KEY_COUNT];
   logic [KEY_COUNT-1:0] valid_ff;
   logic                 rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_enable) begin
         valid_ff[wr_index] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_enable) begin
         mem[wr_index] <= wr_data;
      end
   end

   // write-first: a write on the same edge to the same key wins
   always_ff @(posedge clock) begin
      if (rd_enable) begin
         if (wr_enable && (wr_index == rd_index)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= valid_ff[rd_index] & mem[rd_index];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/scs1_out_seq.sv @@
module scs1_out_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  scs1_pkg::bundle_type in_bundle,
   scs1_rsp_if.source           rsp_chan
);
   import scs1_pkg::*;

   bundle_type bundle_ff;
   logic       valid_ff;
   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic [1:0] last_idx;
   logic       is_last;
   logic       done;
   logic       has_char;

   assign has_char = (bundle_ff.count != 3'd0);
   assign last_idx = has_char ? 2'(bundle_ff.count - 3'd1) : 2'd0;
   assign is_last  = (idx_ff == last_idx);
   assign done     = valid_ff && rsp_chan.ready && is_last;
   assign in_ready = !valid_ff || done;
   assign idx_in   = idx_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (in_valid && in_ready) begin
         valid_ff <= 1'b1;
         idx_ff   <= 2'd0;
      end else if (done) begin
         valid_ff <= 1'b0;
      end else if (valid_ff && rsp_chan.ready) begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         bundle_ff <= in_bundle;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.has_char       = has_char;
   assign rsp_chan.out_char       = has_char ? bundle_ff.chars[idx_ff] : 8'h00;
   assign rsp_chan.last           = is_last;
   assign rsp_chan.reboot_request = bundle_ff.reboot;
   assign rsp_chan.caps_on        = bundle_ff.locks[LOCK_CAPS];
   assign rsp_chan.num_on         = bundle_ff.locks[LOCK_NUM];
   assign rsp_chan.scroll_on      = bundle_ff.locks[LOCK_SCROLL];

endmodule

@@ sv/scancode_set1_keyboard_decoder.sv @@
// Scan code set 1 keyboard decoder.
// req_chan carries one item per transfer: either a scan code byte (kind 0) or a
// keymap entry write (kind 1, code is the key index). rsp_chan gives one to four
// results per item; last marks the final one, and an item with no character
// still gives a single result with has_char low. Lock states and the reboot
// flag ride along on every result of the item.
// The csr port writes repeat_enable and layout_select; the user is to write them
// only while idle, which the block does not enforce. Results leave the result
// register, which follows the decode stage register. One item per cycle is taken
// while each gives one result and the receiver is ready; a multi-character item
// holds the result register until its last result is taken. The keymap and
// the held-key bitmap sit in simple dual-port synchronous memories read on the
// transfer edge; the decode stage after them updates modifier and lock state, and
// a same-key write-first path covers back-to-back codes. A stalled receiver keeps
// the result register full, the decode stage then holds its item and
// req_chan.ready drops. Reset clears the held keys, modifiers, locks and prefix,
// sets repeat_enable and selects layout 0; the keymap is undefined until loaded.
module scancode_set1_keyboard_decoder #(
   parameter int LAYOUTS        = scs1_pkg::LAYOUTS_DEFAULT,
   parameter int KEYMAP_ENTRIES = scs1_pkg::KEYMAP_ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   scs1_req_if.sink                          req_chan,
   scs1_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic                              csr_index,
   input  logic [scs1_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import scs1_pkg::*;

   // configuration
   logic       repeat_en_ff;
   logic [1:0] layout_ff;

   // decode stage
   logic       b_valid_ff;
   logic       b_kind_ff;
   char_type   b_code_ff;

   // key state
   logic       prefix_ff;
   logic       prefix_in;
   logic [5:0] mods_ff;
   logic [5:0] mods_in;
   logic [2:0] locks_ff;
   logic [2:0] locks_in;

   logic       accept;
   logic       b_fire;
   logic       bundle_ready;
   bundle_type bundle;

   logic            km_we;
   logic            km_re;
   entry_type [1:0] km_rd;
   logic            kd_re;
   logic            kd_we;
   logic            kd_rd;

   logic       key_event;
   logic       make;
   key_type    base;
   logic       rep;
   logic       allow;
   logic       ext;
   logic       shift_on;
   logic       ctrl_on;
   logic       alt_on;
   logic       upper;
   entry_type  entry;
   char_type   ch;
   char_type   ch_folded;

   // ------------------------------------------------------------ configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_en_ff <= 1'b1;
         layout_ff    <= 2'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REPEAT_ENABLE: repeat_en_ff <= csr_write_data[0];
            CSR_LAYOUT_SELECT: begin
               // a layout at or above LAYOUTS keeps the old one
               if (int'(csr_write_data[1:0]) < LAYOUTS) begin
                  layout_ff <= csr_write_data[1:0];
               end
            end
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ memory access
   assign accept         = req_chan.valid && req_chan.ready;
   assign b_fire         = b_valid_ff && bundle_ready;
   assign req_chan.ready = !b_valid_ff || bundle_ready;

   assign km_we = accept && (req_chan.kind == KIND_MAP_WRITE)
                  && (int'(req_chan.map_layout) < LAYOUTS)
                  && (int'(req_chan.code) < KEYMAP_ENTRIES);
   assign km_re = accept && (req_chan.kind == KIND_SCAN)
                  && (int'(req_chan.code[6:0]) < KEYMAP_ENTRIES);
   assign kd_re = accept && (req_chan.kind == KIND_SCAN);

   scs1_keymap_ram #(
      .LAYOUTS        (LAYOUTS),
      .KEYMAP_ENTRIES (KEYMAP_ENTRIES)
   ) u_keymap (
      .clock     (clock),
      .wr_enable (km_we),
      .wr_layout (req_chan.map_layout),
      .wr_upper  (req_chan.map_upper),
      .wr_index  (req_chan.code[6:0]),
      .wr_data   (req_chan.map_entry),
      .rd_enable (km_re),
      .rd_layout (layout_ff),
      .rd_index  (req_chan.code[6:0]),
      .rd_data   (km_rd)
   );

   scs1_keydown_ram u_keydown (
      .clock     (clock),
      .reset     (reset),
      .wr_enable (kd_we),
      .wr_index  (base),
      .wr_data   (make),
      .rd_enable (kd_re),
      .rd_index  (req_chan.code[6:0]),
      .rd_data   (kd_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (accept) begin
         b_valid_ff <= 1'b1;
      end else if (b_fire) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_kind_ff <= req_chan.kind;
         b_code_ff <= req_chan.code;
      end
   end

   // ------------------------------------------------------------ decode stage
   assign key_event = (b_kind_ff == KIND_SCAN) && (b_code_ff != SC_PREFIX_EXT)
                      && (b_code_ff != SC_PREFIX_PAUSE);
   assign make  = !b_code_ff[7];
   assign base  = b_code_ff[6:0];
   assign rep   = make && kd_rd;
   assign allow = !rep || repeat_en_ff;
   assign ext   = prefix_ff;
   assign kd_we = b_fire && key_event;

   always_comb begin
      mods_in   = mods_ff;
      locks_in  = locks_ff;
      prefix_in = prefix_ff;
      if (b_kind_ff == KIND_SCAN) begin
         if (b_code_ff == SC_PREFIX_EXT) begin
            prefix_in = 1'b1;
         end else if (b_code_ff == SC_PREFIX_PAUSE) begin
            prefix_in = 1'b0;
         end else begin
            prefix_in = 1'b0;
            unique case (base)
               KEY_LSHIFT: mods_in[MOD_SHIFT_L] = make;
               KEY_RSHIFT: mods_in[MOD_SHIFT_R] = make;
               KEY_CTRL: begin
                  if (ext) mods_in[MOD_CTRL_R] = make;
                  else     mods_in[MOD_CTRL_L] = make;
               end
               KEY_ALT: begin
                  if (ext) mods_in[MOD_ALT_R] = make;
                  else     mods_in[MOD_ALT_L] = make;
               end
               KEY_CAPS:   if (make && !rep) locks_in[LOCK_CAPS]   = !locks_ff[LOCK_CAPS];
               KEY_NUM:    if (make && !rep) locks_in[LOCK_NUM]    = !locks_ff[LOCK_NUM];
               KEY_SCROLL: if (make && !rep) locks_in[LOCK_SCROLL] = !locks_ff[LOCK_SCROLL];
               default: ;
            endcase
         end
      end
   end

   assign shift_on = mods_in[MOD_SHIFT_L] | mods_in[MOD_SHIFT_R];
   assign ctrl_on  = mods_in[MOD_CTRL_L]  | mods_in[MOD_CTRL_R];
   assign alt_on   = mods_in[MOD_ALT_L]   | mods_in[MOD_ALT_R];
   assign upper    = shift_on ^ locks_in[LOCK_CAPS];
   assign entry    = km_rd[upper];
   assign ch       = entry[7:0];

   // ctrl folds letters to upper case before the control range check
   assign ch_folded = ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z)) ? (ch - CH_CASE_BIT) : ch;

   always_comb begin
      bundle        = '0;
      bundle.locks  = locks_in;
      if (key_event && make) begin
         if (ext) begin
            if (base == KEY_ENTER) begin
               if (allow) begin
                  bundle.chars[0] = CH_NEWLINE;
                  bundle.count    = 3'd1;
               end
            end else if ((base == KEY_DELETE) && ctrl_on && alt_on && !rep) begin
               bundle.reboot = 1'b1;
            end else if (allow) begin
               bundle.chars[0] = CH_ESC;
               bundle.chars[1] = CH_BRACKET;
               case (base)
                  KEY_UP:    begin bundle.chars[2] = CH_FIN_UP;    bundle.count = 3'd3; end
                  KEY_DOWN:  begin bundle.chars[2] = CH_FIN_DOWN;  bundle.count = 3'd3; end
                  KEY_LEFT:  begin bundle.chars[2] = CH_FIN_LEFT;  bundle.count = 3'd3; end
                  KEY_RIGHT: begin bundle.chars[2] = CH_FIN_RIGHT; bundle.count = 3'd3; end
                  KEY_HOME:  begin bundle.chars[2] = CH_FIN_HOME;  bundle.count = 3'd3; end
                  KEY_END:   begin bundle.chars[2] = CH_FIN_END;   bundle.count = 3'd3; end
                  KEY_DELETE: begin
                     bundle.chars[2] = CH_THREE;
                     bundle.chars[3] = CH_TILDE;
                     bundle.count    = 3'd4;
                  end
                  default: ;
               endcase
            end
         end else if (base == KEY_BACKSPACE) begin
            if (allow) begin
               bundle.chars[0] = CH_BACKSPACE;
               bundle.count    = 3'd1;
            end
         end else if ((int'(base) < KEYMAP_ENTRIES) && (entry != 9'd0) && allow) begin
            if (base == KEY_ENTER) begin
               bundle.chars[0] = CH_NEWLINE;
               bundle.count    = 3'd1;
            end else if (!entry[8]) begin
               bundle.count = 3'd1;
               if (ctrl_on && !alt_on && (ch_folded >= CH_AT) && (ch_folded <= CH_UNDERSCORE)) begin
                  bundle.chars[0] = ch_folded - CH_AT;
               end else begin
                  bundle.chars[0] = ch;
               end
            end
         end
      end
      if (!(key_event && make && (bundle.count != 3'd0))) begin
         bundle.chars = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= 1'b0;
         mods_ff   <= '0;
         locks_ff  <= '0;
      end else if (b_fire) begin
         prefix_ff <= prefix_in;
         mods_ff   <= mods_in;
         locks_ff  <= locks_in;
      end
   end

   scs1_out_seq u_out_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid_ff),
      .in_ready  (bundle_ready),
      .in_bundle (bundle),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ dv/scancode_set1_keyboard_decoder_checker.sv @@
module scancode_set1_keyboard_decoder_checker #(
   parameter int LAYOUTS        = scs1_pkg::LAYOUTS_DEFAULT,
   parameter int KEYMAP_ENTRIES = scs1_pkg::KEYMAP_ENTRIES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   scs1_req_if                             req_mon,
   scs1_rsp_if                             rsp_mon,
   input  logic                            csr_write_enable,
   input  logic                            csr_index,
   input  logic [scs1_pkg::CSR_DATA_W-1:0] csr_write_data,
   output int                              failures,
   output int                              outstanding,
   output int                              results_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import scs1_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic     has_char;
      char_type out_char;
      logic     last;
      logic     reboot;
      logic     caps;
      logic     num;
      logic     scroll;
   } result_type;

   bit         key_held [KEY_COUNT];
   logic [5:0] mods;
   logic [2:0] locks;
   bit         ext_pending;
   entry_type  keymap [LAYOUTS][2][KEYMAP_ENTRIES];
   bit         repeat_on;
   int         layout_sel;
   result_type char_results_q [$];
   char_type   char_buf [$];
   int         fail_count;
   int         checked;

   function automatic bit shift_held();
      return mods[MOD_SHIFT_L] | mods[MOD_SHIFT_R];
   endfunction

   function automatic bit ctrl_held();
      return mods[MOD_CTRL_L] | mods[MOD_CTRL_R];
   endfunction

   function automatic bit alt_held();
      return mods[MOD_ALT_L] | mods[MOD_ALT_R];
   endfunction

   task automatic push_char(input char_type c);
      if (char_buf.size() < MAX_CHARS) char_buf.push_back(c);
   endtask

   task automatic update_modifiers(input key_type base, input bit make, input bit ext,
                                   input bit rep);
      case (base)
         KEY_LSHIFT: mods[MOD_SHIFT_L] = make;
         KEY_RSHIFT: mods[MOD_SHIFT_R] = make;
         KEY_CTRL:   mods[ext ? MOD_CTRL_R : MOD_CTRL_L] = make;
         KEY_ALT:    mods[ext ? MOD_ALT_R : MOD_ALT_L] = make;
         KEY_CAPS:   if (make && !rep) locks[LOCK_CAPS] = ~locks[LOCK_CAPS];
         KEY_NUM:    if (make && !rep) locks[LOCK_NUM] = ~locks[LOCK_NUM];
         KEY_SCROLL: if (make && !rep) locks[LOCK_SCROLL] = ~locks[LOCK_SCROLL];
         default: ;
      endcase
   endtask

   task automatic push_cursor(input key_type base);
      char_type fin;
      case (base)
         KEY_UP:    fin = CH_FIN_UP;
         KEY_DOWN:  fin = CH_FIN_DOWN;
         KEY_LEFT:  fin = CH_FIN_LEFT;
         KEY_RIGHT: fin = CH_FIN_RIGHT;
         KEY_HOME:  fin = CH_FIN_HOME;
         KEY_END:   fin = CH_FIN_END;
         KEY_DELETE: begin
            push_char(CH_ESC);
            push_char(CH_BRACKET);
            push_char(CH_THREE);
            push_char(CH_TILDE);
            return;
         end
         default: return;
      endcase
      push_char(CH_ESC);
      push_char(CH_BRACKET);
      push_char(fin);
   endtask

   task automatic translate_key(input key_type base, input bit allow);
      entry_type entry;
      char_type  c;
      int        upper;
      if (base >= KEYMAP_ENTRIES || layout_sel >= LAYOUTS) return;
      upper = (shift_held() ^ locks[LOCK_CAPS]) ? 1 : 0;
      entry = keymap[layout_sel][upper][base];
      if (entry == '0) return;
      if (base == KEY_ENTER) begin
         if (allow) push_char(CH_NEWLINE);
         return;
      end
      // strings only ever give newline on enter
      if (entry[8]) return;
      c = entry[7:0];
      if (ctrl_held() && !alt_held()) begin
         if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CH_CASE_BIT;
         if (c >= CH_AT && c <= CH_UNDERSCORE) begin
            if (allow) push_char(c - CH_AT);
            return;
         end
      end
      if (allow) push_char(c);
   endtask

   task automatic decode_item(input logic kind, input char_type code, input logic [1:0] lay,
                              input logic up, input entry_type ent);
      bit         ext;
      bit         make;
      bit         rep;
      bit         allow;
      bit         reboot;
      key_type    base;
      result_type r;
      int         n;
      char_buf.delete();
      reboot = 1'b0;
      if (kind == KIND_MAP_WRITE) begin
         if (lay < LAYOUTS && code < KEYMAP_ENTRIES) keymap[lay][up][code] = ent;
      end else if (code == SC_PREFIX_EXT) begin
         ext_pending = 1'b1;
      end else if (code == SC_PREFIX_PAUSE) begin
         ext_pending = 1'b0;
      end else begin
         ext   = ext_pending;
         make  = !code[7];
         base  = code[6:0];
         rep   = make && key_held[base];
         allow = !rep || repeat_on;
         key_held[base] = make;
         update_modifiers(base, make, ext, rep);
         if (ext) begin
            ext_pending = 1'b0;
            if (make) begin
               if (base == KEY_ENTER) begin
                  if (allow) push_char(CH_NEWLINE);
               end else if (base == KEY_DELETE && ctrl_held() && alt_held() && !rep) begin
                  reboot = 1'b1;
               end else if (allow) begin
                  push_cursor(base);
               end
            end
         end else if (base == KEY_BACKSPACE) begin
            if (make && allow) push_char(CH_BACKSPACE);
         end else if (make) begin
            translate_key(base, allow);
         end
      end
      n = (char_buf.size() > 0) ? char_buf.size() : 1;
      for (int k = 0; k < n; k++) begin
         r.has_char = char_buf.size() > 0;
         r.out_char = r.has_char ? char_buf[k] : '0;
         r.last     = (k == n - 1);
         r.reboot   = reboot;
         r.caps     = locks[LOCK_CAPS];
         r.num      = locks[LOCK_NUM];
         r.scroll   = locks[LOCK_SCROLL];
         char_results_q.push_back(r);
      end
   endtask

   task automatic check_result();
      result_type want;
      result_type got;
      got.has_char = rsp_mon.has_char;
      got.out_char = rsp_mon.out_char;
      got.last     = rsp_mon.last;
      got.reboot   = rsp_mon.reboot_request;
      got.caps     = rsp_mon.caps_on;
      got.num      = rsp_mon.num_on;
      got.scroll   = rsp_mon.scroll_on;
      checked++;
      if (char_results_q.size() == 0) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("unexpected result: has_char %0b char %02h last %0b reboot %0b",
                     got.has_char, got.out_char, got.last, got.reboot);
         return;
      end
      want = char_results_q.pop_front();
      if (got.has_char !== want.has_char || got.out_char !== want.out_char ||
          got.last !== want.last || got.reboot !== want.reboot ||
          got.caps !== want.caps || got.num !== want.num || got.scroll !== want.scroll) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS) begin
            $display("mismatch at result %0d: expected has_char %0b char %02h last %0b reboot %0b locks %0b%0b%0b",
                     checked, want.has_char, want.out_char, want.last, want.reboot,
                     want.caps, want.num, want.scroll);
            $display("                       actual   has_char %0b char %02h last %0b reboot %0b locks %0b%0b%0b",
                     got.has_char, got.out_char, got.last, got.reboot,
                     got.caps, got.num, got.scroll);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (key_held[i]) key_held[i] = 1'b0;
         mods        = '0;
         locks       = '0;
         ext_pending = 1'b0;
         repeat_on   = 1'b1;
         layout_sel  = 0;
         char_results_q.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_REPEAT_ENABLE) repeat_on = csr_write_data[0];
            else if (csr_write_data < LAYOUTS) layout_sel = int'(csr_write_data);
         end
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (req_mon.valid && req_mon.ready)
            decode_item(req_mon.kind, req_mon.code, req_mon.map_layout, req_mon.map_upper,
                        req_mon.map_entry);
      end
      outstanding     <= char_results_q.size();
      failures        <= fail_count;
      results_checked <= checked;
   end

endmodule

@@ dv/scancode_set1_keyboard_decoder_test.sv @@
module scancode_set1_keyboard_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;
   import scs1_pkg::*;

   localparam int      RESET_CYCLES = 6;
   localparam int      RUN_LIMIT    = 600000;
   localparam int      PHASE_ITEMS  = 28;
   localparam int      PHASES       = 4;
   localparam int      MAX_GAP      = 12;
   localparam key_type KEY_A        = 7'h1E;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic                  csr_index        = 1'b0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;

   int fail_total;
   int outstanding;
   int results_checked;
   int cycle_count   = 0;
   int scans_sent    = 0;
   int writes_sent   = 0;
   int settings_used = 0;
   bit calm          = 1'b0;
   bit loaded [LAYOUTS_DEFAULT][KEY_COUNT];
   int cur_layout    = 0;
   bit ext_armed     = 1'b0;

   scs1_req_if req_chan ();
   scs1_rsp_if rsp_chan ();

   scancode_set1_keyboard_decoder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   scancode_set1_keyboard_decoder_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .failures         (fail_total),
      .outstanding      (outstanding),
      .results_checked  (results_checked)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("run stopped after %0d cycles with %0d results still due",
                  cycle_count, outstanding);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   task automatic send_item(input item_kind_type kind, input char_type code,
                            input logic [1:0] lay, input logic up, input entry_type ent);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.kind       <= kind;
      req_chan.code       <= code;
      req_chan.map_layout <= lay;
      req_chan.map_upper  <= up;
      req_chan.map_entry  <= ent;
      do @(posedge clock); while (!req_chan.ready);
      if (kind == KIND_SCAN) scans_sent++;
      else writes_sent++;
   endtask

   function automatic entry_type make_entry(input bit upper);
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 14) return entry_type'($urandom_range(256, 511));
      if (r < 50) begin
         if (upper)
            return entry_type'($urandom_range(CH_LOWER_A - CH_CASE_BIT,
                                              CH_LOWER_Z - CH_CASE_BIT));
         return entry_type'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
      end
      if (r < 65) return entry_type'($urandom_range(CH_AT, CH_UNDERSCORE));
      return entry_type'($urandom_range(1, 255));
   endfunction

   // map fields are don't-care on scan bytes, so keep them moving
   task automatic scan(input char_type code);
      key_type key;
      key = code[6:0];
      // load both halves of a key's entry just before its first lookup
      if (!ext_armed && !code[7] && (key != KEY_BACKSPACE) && !loaded[cur_layout][key]) begin
         send_item(KIND_MAP_WRITE, char_type'(key), 2'(cur_layout), 1'b0, make_entry(1'b0));
         send_item(KIND_MAP_WRITE, char_type'(key), 2'(cur_layout), 1'b1, make_entry(1'b1));
         loaded[cur_layout][key] = 1'b1;
      end
      ext_armed = (code == SC_PREFIX_EXT);
      send_item(KIND_SCAN, code, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                entry_type'($urandom_range(0, 511)));
   endtask

   task automatic press(input key_type key, input bit ext);
      if (ext) scan(SC_PREFIX_EXT);
      scan({1'b0, key});
   endtask

   task automatic lift(input key_type key, input bit ext);
      if (ext) scan(SC_PREFIX_EXT);
      scan({1'b1, key});
   endtask

   task automatic set_registers(input logic rep, input logic [1:0] lay);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_REPEAT_ENABLE;
      csr_write_data   <= CSR_DATA_W'(rep);
      @(posedge clock);
      csr_index        <= CSR_LAYOUT_SELECT;
      csr_write_data   <= lay;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (int'(lay) < LAYOUTS_DEFAULT) cur_layout = int'(lay);
      settings_used++;
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic key_type pick_key();
      int      r;
      key_type cursor [7];
      cursor = '{KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT, KEY_HOME, KEY_END, KEY_DELETE};
      r = $urandom_range(0, 9);
      if (r < 6) return key_type'($urandom_range(8'h10, 8'h32));
      if (r < 8) return cursor[$urandom_range(0, 6)];
      if (r == 8) return ($urandom_range(0, 1) != 0) ? KEY_BACKSPACE : KEY_ENTER;
      return key_type'($urandom_range(0, KEY_COUNT - 1));
   endfunction

   task automatic random_burst();
      int      pick;
      int      reps;
      key_type key;
      bit      ext;
      key_type mod_keys [4];
      key_type lock_keys [3];
      mod_keys  = '{KEY_LSHIFT, KEY_RSHIFT, KEY_CTRL, KEY_ALT};
      lock_keys = '{KEY_CAPS, KEY_NUM, KEY_SCROLL};
      if ($urandom_range(0, 9) == 0) calm = !calm;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         // tap with optional held repeats
         key  = pick_key();
         ext  = ($urandom_range(0, 3) == 0);
         reps = $urandom_range(0, 2);
         press(key, ext);
         repeat (reps) press(key, ext);
         if ($urandom_range(0, 4) != 0) lift(key, ext);
      end else if (pick < 60) begin
         key = mod_keys[$urandom_range(0, 3)];
         ext = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 1) != 0) press(key, ext);
         else lift(key, ext);
      end else if (pick < 70) begin
         key = lock_keys[$urandom_range(0, 2)];
         press(key, 1'b0);
         if ($urandom_range(0, 3) == 0) press(key, 1'b0);
         lift(key, 1'b0);
      end else if (pick < 78) begin
         press(KEY_CTRL, 1'($urandom_range(0, 1)));
         press(KEY_ALT, 1'($urandom_range(0, 1)));
         press(KEY_DELETE, 1'b1);
         if ($urandom_range(0, 2) == 0) press(KEY_DELETE, 1'b1);
         lift(KEY_DELETE, 1'b1);
         if ($urandom_range(0, 1) != 0) lift(KEY_CTRL, 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 1) != 0) lift(KEY_ALT, 1'($urandom_range(0, 1)));
      end else if (pick < 90) begin
         scan(char_type'($urandom_range(0, 255)));
      end else begin
         send_item(KIND_MAP_WRITE, char_type'($urandom_range(0, 255)),
                   2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   entry_type'($urandom_range(0, 511)));
      end
   endtask

   initial begin : receiver
      int gap;
      rsp_chan.ready = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin : stimulus
      logic       phase_repeat [PHASES];
      logic [1:0] phase_layout [PHASES];
      int         phase_start;
      phase_repeat = '{1'b0, 1'b1, 1'b0, 1'b1};
      // the select of three is invalid and leaves layout two in place
      phase_layout = '{2'd2, 2'd3, 2'd1, 2'd0};
      req_chan.valid      = 1'b0;
      req_chan.kind       = KIND_SCAN;
      req_chan.code       = '0;
      req_chan.map_layout = '0;
      req_chan.map_upper  = 1'b0;
      req_chan.map_entry  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      set_registers(1'b1, 2'd0);

      press(KEY_A, 1'b0);
      press(KEY_A, 1'b0);
      lift(KEY_A, 1'b0);
      press(KEY_LSHIFT, 1'b0);
      press(KEY_A, 1'b0);
      lift(KEY_LSHIFT, 1'b0);
      press(KEY_CAPS, 1'b0);
      press(KEY_NUM, 1'b0);
      press(KEY_SCROLL, 1'b0);
      press(KEY_BACKSPACE, 1'b0);
      press(KEY_ENTER, 1'b0);
      press(KEY_UP, 1'b1);
      press(KEY_DELETE, 1'b1);
      lift(KEY_DELETE, 1'b1);
      press(KEY_CTRL, 1'b0);
      press(KEY_ALT, 1'b1);
      press(KEY_DELETE, 1'b1);
      scan(SC_PREFIX_PAUSE);
      press(KEY_LSHIFT, 1'b1);
      scan(8'h00);
      scan(8'hFF);
      send_item(KIND_MAP_WRITE, 8'hFF, 2'd3, 1'b1, 9'h1FF);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         set_registers(phase_repeat[p], phase_layout[p]);
         phase_start = scans_sent + writes_sent;
         while (scans_sent + writes_sent - phase_start < PHASE_ITEMS) random_burst();
         wait_idle();
      end

      $display("checked %0d results from %0d scan bytes and %0d keymap writes",
               results_checked, scans_sent, writes_sent);
      $display("%0d register settings: repeat on and off, layouts 0 to 2, one invalid select",
               settings_used);
      if (fail_total == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d results failed", fail_total);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
